FILE: rtl/chs_pkg.sv
package chs_pkg;

  localparam int KEY_W   = 32;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 9;
  localparam int OUT_W   = 16;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

endpackage

FILE: rtl/chs_ram.sv
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/chained_hash_set_engine.sv
// From accept to result: ST_HEAD reads the bucket head, ST_WALK visits each chain entry,
// then ST_FOUND or ST_MISS, ST_RM2 (remove hit) or ST_POP (free-list insert), then ST_DONE.
// Throughput: one operation at a time; the chain walk through the entry RAM read port sets it.
// A clear returns its result and then sweeps the bucket RAM, setting every bucket to empty.
// Reset (synchronous, active high) runs the same sweep of the bucket RAM; no input is taken then.
// BUCKETS must be a power of two: the bucket is the key's low bits.
module chained_hash_set_engine #(
  parameter int BUCKETS = 256,
  parameter int ENTRIES = 256
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [chs_pkg::KEY_W-1:0] s_tdata,   // key
  input  logic [chs_pkg::OP_W-1:0]  s_tuser,   // operation
  output logic                      m_tvalid,
  input  logic                      m_tready,
  output logic [chs_pkg::OUT_W-1:0] m_tdata    // hit, status, live_count[8:0], zero fill
);

  import chs_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int EW = $clog2(ENTRIES);
  localparam int IW = EW + 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam int DW = IW + KEY_W;
  localparam logic [IW-1:0] NIL = '1;
  localparam logic [IW-1:0] ENT_LIMIT = IW'(ENTRIES);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_HEAD  = 10'b0000000100,
    ST_WALK  = 10'b0000001000,
    ST_FOUND = 10'b0000010000,
    ST_MISS  = 10'b0000100000,
    ST_POP   = 10'b0001000000,
    ST_RM2   = 10'b0010000000,
    ST_DONE  = 10'b0100000000,
    ST_SWEEP = 10'b1000000000
  } state_t;

  state_t            state;
  op_t               op;
  logic [KEY_W-1:0]  key;
  logic [IW-1:0]     head;
  logic [IW-1:0]     cur;
  logic [IW-1:0]     found_link;
  logic [IW-1:0]     prev;
  logic [KEY_W-1:0]  prev_key;
  logic [IW-1:0]     steps;
  logic [IW-1:0]     free_top;
  logic [IW-1:0]     next_unused;
  logic [CW-1:0]     count;
  logic [BW-1:0]     clr_addr;
  logic              res_hit;
  status_t           res_status;
  logic              pend_clear;

  logic              b_we;
  logic [BW-1:0]     b_waddr;
  logic [IW-1:0]     b_wdata;
  logic [BW-1:0]     b_raddr;
  logic [IW-1:0]     b_rdata;
  logic              e_we;
  logic [EW-1:0]     e_waddr;
  logic [DW-1:0]     e_wdata;
  logic [EW-1:0]     e_raddr;
  logic [DW-1:0]     e_rdata;
  logic [KEY_W-1:0]  rd_key;
  logic [IW-1:0]     rd_link;
  logic [IW-1:0]     steps_next;

  assign rd_key     = e_rdata[KEY_W-1:0];
  assign rd_link    = e_rdata[DW-1:KEY_W];
  assign steps_next = steps + IW'(1);
  assign s_tready   = (state == ST_IDLE);

  chs_ram #(.WIDTH(IW), .DEPTH(BUCKETS)) u_bucket_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  chs_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  always_comb begin
    b_we    = 1'b0;
    b_waddr = key[BW-1:0];
    b_wdata = NIL;
    b_raddr = s_tdata[BW-1:0];
    e_we    = 1'b0;
    e_waddr = cur[EW-1:0];
    e_wdata = {head, key};
    e_raddr = cur[EW-1:0];
    unique case (state)
      ST_CLEAR, ST_SWEEP: begin
        b_we    = 1'b1;
        b_waddr = clr_addr;
      end
      ST_HEAD: begin
        e_raddr = b_rdata[EW-1:0];
      end
      ST_WALK: begin
        e_raddr = rd_link[EW-1:0];
      end
      ST_FOUND: begin
        if (op == OP_REMOVE) begin
          if (prev == NIL) begin
            b_we    = 1'b1;
            b_wdata = found_link;
          end else begin
            e_we    = 1'b1;
            e_waddr = prev[EW-1:0];
            e_wdata = {found_link, prev_key};
          end
        end
      end
      ST_MISS: begin
        e_raddr = free_top[EW-1:0];
        if (op == OP_INSERT && free_top >= ENT_LIMIT && next_unused < ENT_LIMIT) begin
          b_we    = 1'b1;
          b_wdata = next_unused;
          e_we    = 1'b1;
          e_waddr = next_unused[EW-1:0];
        end
      end
      ST_POP: begin
        b_we    = 1'b1;
        b_wdata = free_top;
        e_we    = 1'b1;
        e_waddr = free_top[EW-1:0];
      end
      ST_RM2: begin
        e_we    = 1'b1;
        e_wdata = {free_top, key};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= LAST_BUCKET;
      free_top    <= NIL;
      next_unused <= '0;
      count       <= '0;
      m_tvalid    <= 1'b0;
      pend_clear  <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR, ST_SWEEP: begin
          clr_addr <= clr_addr - BW'(1);
          if (clr_addr == '0) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op         <= op_t'(s_tuser);
            key        <= s_tdata;
            res_hit    <= 1'b0;
            res_status <= STATUS_OK;
            pend_clear <= (op_t'(s_tuser) == OP_CLEAR);
            if (op_t'(s_tuser) == OP_CLEAR) begin
              free_top    <= NIL;
              next_unused <= '0;
              count       <= '0;
              clr_addr    <= LAST_BUCKET;
              state       <= ST_DONE;
            end else begin
              state <= ST_HEAD;
            end
          end
        end
        ST_HEAD: begin
          head  <= b_rdata;
          cur   <= b_rdata;
          prev  <= NIL;
          steps <= '0;
          state <= (b_rdata < ENT_LIMIT) ? ST_WALK : ST_MISS;
        end
        ST_WALK: begin
          if (rd_key == key) begin
            found_link <= rd_link;
            state      <= ST_FOUND;
          end else begin
            prev     <= cur;
            prev_key <= rd_key;
            cur      <= rd_link;
            steps    <= steps_next;
            if (!(rd_link < ENT_LIMIT && steps_next < ENT_LIMIT)) begin
              state <= ST_MISS;
            end
          end
        end
        ST_FOUND: begin
          case (op)
            OP_LOOKUP: begin
              res_hit <= 1'b1;
              state   <= ST_DONE;
            end
            OP_REMOVE: state <= ST_RM2;
            default:   state <= ST_DONE;
          endcase
        end
        ST_RM2: begin
          free_top <= cur;
          if (count != '0) begin
            count <= count - CW'(1);
          end
          res_hit <= 1'b1;
          state   <= ST_DONE;
        end
        ST_MISS: begin
          if (op == OP_INSERT && free_top < ENT_LIMIT) begin
            state <= ST_POP;
          end else begin
            state <= ST_DONE;
            if (op == OP_INSERT) begin
              if (next_unused < ENT_LIMIT) begin
                next_unused <= next_unused + IW'(1);
                count       <= count + CW'(1);
                res_hit     <= 1'b1;
              end else begin
                res_status <= STATUS_FULL;
              end
            end
          end
        end
        ST_POP: begin
          free_top <= rd_link;
          count    <= count + CW'(1);
          res_hit  <= 1'b1;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({COUNT_W'(count), res_status, res_hit});
            state    <= pend_clear ? ST_SWEEP : ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
